>>> design/dfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg - shared definitions for the delimited frame receiver
// Character codes, phase and result kind codes, counter widths and the
// queue entry type passed from the classifier to the result stage.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int COUNT_BITS = 11;
	localparam int CFG_BITS   = 11;
	localparam int LIM_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

	localparam logic [LIM_BITS-1:0] COUNT_MASK = LIM_BITS'({COUNT_BITS{1'b1}});
	localparam logic [CFG_BITS-1:0] MAX_PAYLOAD_RESET = CFG_BITS'(1500);

	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;

	localparam logic [1:0] PH_HUNT1 = 2'd0;
	localparam logic [1:0] PH_HUNT2 = 2'd1;
	localparam logic [1:0] PH_RECV  = 2'd2;
	localparam logic [1:0] PH_STOP1 = 2'd3;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_OVER    = 2'd2;
	localparam logic [1:0] KIND_NOEND   = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// One classified input item: either a single result, or an escaped pair
	// that expands to a '!' payload byte followed by the data byte.
	typedef struct packed {
		logic       pair;
		logic [7:0] data;
		logic [1:0] kind;
	} entry_t;

endpackage

`default_nettype wire

>>> design/delimited_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_frame_receiver - two-byte delimiter deframer
// Hunts for the start pair '!','&', streams payload bytes until '!','#' and
// reports frame completion, payload overflow and a missing end character.
// ----------------------------------------------------------------------------
// A result item for an accepted byte is written into the queue by the accepting
// edge and then loaded from the queue head into the output register once it is free.
// Throughput: one byte per cycle; an escaped pair yields two result items, and
// input stalls only once the four-entry queue between the two halves is full.
// Reset (arst_n low, asynchronous): hunting for '!', payload count zero, queue
// and output register empty, max_payload back to 1500.
// ----------------------------------------------------------------------------
module delimited_frame_receiver (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Configuration: max_payload, written whenever cfg_wen is high.
	input  wire logic                         cfg_wen,
	input  wire logic [dfr_pkg::CFG_BITS-1:0] cfg_wdata,
	// Received bytes.
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // [7:0] in_byte
	// Result items.
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]                        m_axis_tuser,  // [1:0] out_kind
	output logic                              m_axis_tlast   // last
);
	import dfr_pkg::*;

	// Classifier to queue.
	logic   push;
	entry_t push_entry;
	logic   q_full;

	// Queue to result stage.
	logic   pop;
	entry_t head;
	logic   q_empty;

	// The classifier owns the phase, the payload count and the limit
	// register. Bytes that cause no result (hunting, or a '!' that waits for
	// its partner) are consumed without touching the queue.
	dfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_byte    (s_axis_tdata),
		.in_ready   (s_axis_tready),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// The queue decouples the two sides, so a stalled output does not stop
	// input until it fills, and an escaped pair is absorbed here.
	dfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty)
	);

	// The result stage turns each entry into one or two result items and
	// keeps them in its output register while the sink is stalled.
	dfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

>>> design/dfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_front - byte classifier
// Tracks the delimiter phase and the payload count, and turns each accepted
// byte into at most one queue entry.
// ----------------------------------------------------------------------------
module dfr_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [dfr_pkg::CFG_BITS-1:0] cfg_wdata,
	input  wire logic                         in_valid,
	input  wire logic [7:0]                   in_byte,
	output logic                              in_ready,
	input  wire logic                         q_full,
	output logic                              push,
	output dfr_pkg::entry_t                   push_entry
);
	import dfr_pkg::*;

	logic [CFG_BITS-1:0]   max_payload_q;
	logic [1:0]            phase_q;
	logic [COUNT_BITS-1:0] count_q;

	logic [1:0]            phase_d;
	logic [COUNT_BITS-1:0] count_d;
	logic                  emit;
	entry_t                entry;
	logic [LIM_BITS-1:0]   cfg_ext;
	logic [LIM_BITS-1:0]   lim;
	logic [LIM_BITS-1:0]   count_ext;
	logic [LIM_BITS:0]     count_plus2;
	logic                  accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign cfg_ext     = LIM_BITS'(max_payload_q);
	assign lim         = (cfg_ext < COUNT_MASK) ? cfg_ext : COUNT_MASK;
	assign count_ext   = LIM_BITS'(count_q);
	assign count_plus2 = {1'b0, count_ext} + (LIM_BITS+1)'(2);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		emit    = 1'b0;
		entry   = '{pair: 1'b0, data: 8'h00, kind: KIND_PAYLOAD};
		unique case (phase_q)
			PH_HUNT1: begin
				if (in_byte == CH_BANG) begin
					phase_d = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				if (in_byte == CH_AMP) begin
					phase_d = PH_RECV;
					count_d = '0;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_RECV: begin
				if (in_byte == CH_BANG) begin
					phase_d = PH_STOP1;
				end else if (count_ext < lim) begin
					count_d = count_q + COUNT_BITS'(1);
					emit    = 1'b1;
					entry   = '{pair: 1'b0, data: in_byte, kind: KIND_PAYLOAD};
				end else begin
					phase_d = PH_HUNT1;
					count_d = '0;
					emit    = 1'b1;
					entry   = '{pair: 1'b0, data: 8'h00, kind: KIND_OVER};
				end
			end
			default: begin
				if (in_byte == CH_HASH) begin
					phase_d = PH_HUNT1;
					count_d = '0;
					emit    = 1'b1;
					entry   = '{pair: 1'b0, data: 8'h00, kind: KIND_DONE};
				end else if (count_plus2 <= {1'b0, lim}) begin
					phase_d = PH_RECV;
					count_d = count_q + COUNT_BITS'(2);
					emit    = 1'b1;
					entry   = '{pair: 1'b1, data: in_byte, kind: KIND_PAYLOAD};
				end else begin
					phase_d = PH_HUNT1;
					count_d = '0;
					emit    = 1'b1;
					entry   = '{pair: 1'b0, data: 8'h00, kind: KIND_NOEND};
				end
			end
		endcase
	end

	assign push       = accept && emit;
	assign push_entry = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
			phase_q       <= PH_HUNT1;
			count_q       <= '0;
		end else begin
			if (cfg_wen) begin
				max_payload_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= phase_d;
				count_q <= count_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/dfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_queue - short entry queue
// Register-based first-in first-out store between classifier and result stage.
// ----------------------------------------------------------------------------
module dfr_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dfr_pkg::entry_t push_entry,
	output logic                 full,
	input  wire logic            pop,
	output dfr_pkg::entry_t      head,
	output logic                 empty
);
	import dfr_pkg::*;

	entry_t               slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;
	logic                 do_pop;

	assign full   = (fill_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty  = (fill_q == '0);
	assign head   = slots_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + (QPTR_BITS+1)'(1);
			end else if (do_pop && !push) begin
				fill_q <= fill_q - (QPTR_BITS+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/dfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_back - result stage
// Expands queue entries into result items and holds them in the output
// register until the downstream side takes them.
// ----------------------------------------------------------------------------
module dfr_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dfr_pkg::entry_t head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic [1:0]           out_kind,
	output logic                 out_last
);
	import dfr_pkg::*;

	logic       valid_q;
	logic       second_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic       load;

	assign load = !empty && (!valid_q || out_ready);
	// A pair entry stays at the head until its second result is loaded.
	assign pop  = load && (!head.pair || second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= head.pair && !second_q;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (head.pair && !second_q) begin
				byte_q <= CH_BANG;
				kind_q <= KIND_PAYLOAD;
				last_q <= 1'b0;
			end else begin
				byte_q <= head.data;
				kind_q <= head.kind;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire
